FILE: sv/aces_filmic_tone_map_unit_defines.svh
// assertion macros shared by the tone map rtl
// no dependencies; taken in by `include in the files that carry checks
`ifndef ACES_FILMIC_TONE_MAP_UNIT_DEFINES_SVH
`define ACES_FILMIC_TONE_MAP_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define AFTM_CHECK(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define AFTM_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/aftm_pkg.sv
// shared constants and types for the tone map pipeline
// no dependencies; used by every module of the block
`default_nettype none

package aftm_pkg;

    // input fixed point format and field widths
    localparam int INPUT_FRAC_BITS = 16;
    localparam int NUM_CH          = 3;
    localparam int IN_W            = 24;
    localparam int OUT_W           = 16;
    localparam int Q_BITS          = 16;

    // derived datapath widths
    localparam int COEF_W = INPUT_FRAC_BITS + 2;
    localparam int PA_W   = COEF_W + IN_W + 1;
    localparam int N_W    = IN_W + 2;
    localparam int DEN_W  = IN_W + N_W;

    // curve coefficients, rounded half up to the input format
    localparam logic [COEF_W-1:0] KA =
        COEF_W'(((64'd251 << INPUT_FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [COEF_W-1:0] KB =
        COEF_W'(((64'd3 << INPUT_FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [COEF_W-1:0] KC =
        COEF_W'(((64'd243 << INPUT_FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [COEF_W-1:0] KD =
        COEF_W'(((64'd59 << INPUT_FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [COEF_W-1:0] KE =
        COEF_W'(((64'd14 << INPUT_FRAC_BITS) + 64'd50) / 64'd100);

    // 1.0 in unsigned q1.15
    localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(32768);

    // one channel as it moves down the divider chain
    typedef struct packed {
        logic [DEN_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [Q_BITS-1:0] quo;
        logic              clamp;
    } aftm_lane_t;

    typedef aftm_lane_t [NUM_CH-1:0]      aftm_pix_t;
    typedef logic [NUM_CH-1:0][IN_W-1:0]  aftm_in_t;
    typedef logic [NUM_CH-1:0][OUT_W-1:0] aftm_out_t;

endpackage

`default_nettype wire

FILE: sv/aftm_front.sv
// front end: coefficient products, numerator and denominator, clamp test
// depends on aftm_pkg; feeds the first divider cell
`default_nettype none

module aftm_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  aftm_pkg::aftm_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aftm_pkg::aftm_pix_t out_data
);
    import aftm_pkg::*;

    logic                               valid_a_reg, valid_a_next;
    logic                               valid_b_reg, valid_b_next;
    logic                               valid_c_reg, valid_c_next;
    logic                               ready_a, ready_b, ready_c;
    logic [NUM_CH-1:0][IN_W-1:0]        x_a_reg;
    logic [NUM_CH-1:0][N_W-1:0]         n_a_reg, m_a_reg;
    logic [NUM_CH-1:0][N_W-1:0]         n_a_next, m_a_next;
    logic [NUM_CH-1:0][DEN_W-1:0]       num_b_reg, den_b_reg;
    logic [NUM_CH-1:0][DEN_W-1:0]       num_b_next, den_b_next;
    aftm_pix_t                          pix_c_reg, pix_c_next;
    logic [NUM_CH-1:0][COEF_W+IN_W-1:0] ka_x, kc_x;
    logic [NUM_CH-1:0][PA_W-1:0]        pa, pc;
    logic [NUM_CH-1:0][DEN_W-1:0]       x_m;

    // stage ready chain, bubbles collapse
    assign ready_c  = !valid_c_reg || out_ready;
    assign ready_b  = !valid_b_reg || ready_c;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    assign out_valid = valid_c_reg;
    assign out_data  = pix_c_reg;

    // stage a: a*x + b and c*x + d, scaled back by the fraction bits
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            ka_x[ch]     = (COEF_W+IN_W)'(KA) * (COEF_W+IN_W)'(in_data[ch]);
            kc_x[ch]     = (COEF_W+IN_W)'(KC) * (COEF_W+IN_W)'(in_data[ch]);
            pa[ch]       = PA_W'(ka_x[ch]) + (PA_W'(KB) << INPUT_FRAC_BITS);
            pc[ch]       = PA_W'(kc_x[ch]) + (PA_W'(KD) << INPUT_FRAC_BITS);
            n_a_next[ch] = pa[ch][INPUT_FRAC_BITS +: N_W];
            m_a_next[ch] = pc[ch][INPUT_FRAC_BITS +: N_W];
        end
    end

    // stage b: numerator and denominator at twice the fraction scale
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            num_b_next[ch] = DEN_W'(x_a_reg[ch]) * DEN_W'(n_a_reg[ch]);
            x_m[ch]        = DEN_W'(x_a_reg[ch]) * DEN_W'(m_a_reg[ch]);
            den_b_next[ch] = x_m[ch] + (DEN_W'(KE) << INPUT_FRAC_BITS);
        end
    end

    // stage c: clamp test and seed for the divider
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            pix_c_next[ch].rem   = num_b_reg[ch];
            pix_c_next[ch].den   = den_b_reg[ch];
            pix_c_next[ch].quo   = '0;
            pix_c_next[ch].clamp = (num_b_reg[ch] >= den_b_reg[ch]);
        end
    end

    // valid bits
    always_comb begin
        valid_a_next = ready_a ? in_valid    : valid_a_reg;
        valid_b_next = ready_b ? valid_a_reg : valid_b_reg;
        valid_c_next = ready_c ? valid_b_reg : valid_c_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end else begin
            valid_a_reg <= valid_a_next;
            valid_b_reg <= valid_b_next;
            valid_c_reg <= valid_c_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ready_a && in_valid) begin
            x_a_reg <= in_data;
            n_a_reg <= n_a_next;
            m_a_reg <= m_a_next;
        end
        if (ready_b && valid_a_reg) begin
            num_b_reg <= num_b_next;
            den_b_reg <= den_b_next;
        end
        if (ready_c && valid_b_reg) begin
            pix_c_reg <= pix_c_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/aftm_div_cell.sv
// one cell of the restoring divider: one quotient bit per channel
// depends on aftm_pkg; cells are chained in the top level
`default_nettype none

module aftm_div_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  aftm_pkg::aftm_pix_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aftm_pkg::aftm_pix_t out_data
);
    import aftm_pkg::*;

    logic                     valid_reg, valid_next;
    aftm_pix_t                pix_reg, pix_next;
    logic [NUM_CH-1:0][DEN_W:0] rem_sh, rem_sub;
    logic [NUM_CH-1:0]        take;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = pix_reg;

    // shift, trial subtract, keep on success
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            rem_sh[ch]         = {in_data[ch].rem, 1'b0};
            rem_sub[ch]        = rem_sh[ch] - {1'b0, in_data[ch].den};
            take[ch]           = (rem_sh[ch] >= {1'b0, in_data[ch].den});
            pix_next[ch].rem   = take[ch] ? rem_sub[ch][DEN_W-1:0] : rem_sh[ch][DEN_W-1:0];
            pix_next[ch].den   = in_data[ch].den;
            pix_next[ch].quo   = {in_data[ch].quo[Q_BITS-2:0], take[ch]};
            pix_next[ch].clamp = in_data[ch].clamp;
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pix_reg <= pix_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/aftm_out_stage.sv
// output register: quotient rounding, clamp to 1.0, result request
// depends on aftm_pkg; fed by the last divider cell
`default_nettype none

module aftm_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  aftm_pkg::aftm_pix_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aftm_pkg::aftm_out_t out_data
);
    import aftm_pkg::*;

    logic                               valid_reg, valid_next;
    aftm_out_t                          res_reg, res_next;
    logic [NUM_CH-1:0][Q_BITS:0]        rounded;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = res_reg;

    // round half up from 16 quotient bits to q1.15, then clamp
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            rounded[ch] = ({1'b0, in_data[ch].quo} + (Q_BITS+1)'(1)) >> 1;
            if (in_data[ch].clamp || rounded[ch] > (Q_BITS+1)'(OUT_ONE)) begin
                res_next[ch] = OUT_ONE;
            end else begin
                res_next[ch] = rounded[ch][OUT_W-1:0];
            end
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/aces_filmic_tone_map_unit.sv
// top level of the aces filmic tone map: front end, divider chain, output
// depends on aftm_pkg, aftm_front, aftm_div_cell, aftm_out_stage and the defines header
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: red_in, green_in, blue_in (24 bits each)
//  m_      | out | m_tvalid/m_tready  | m_tdata: red_out, green_out, blue_out (16 bits each)
//
// one pixel per clock sustained while m_tready is high; from request to result a pixel passes
// three front end stages, sixteen divider cells (one quotient bit each), one output register
// every stage holds one request and its ready ripples back, so a stall on m_ only stops
// the stages that are full behind it; empty stages keep taking requests
// reset (aresetn low, synchronous) clears the valid bits only
`default_nettype none
`include "aces_filmic_tone_map_unit_defines.svh"

module aces_filmic_tone_map_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // red_in [23:0], green_in [47:24], blue_in [71:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // red_out [15:0], green_out [31:16], blue_out [47:32]
);
    import aftm_pkg::*;

    localparam int NUM_CELLS = Q_BITS;

    aftm_in_t                 pix_in;
    aftm_out_t                pix_out;
    logic [NUM_CELLS:0]       chain_valid;
    logic [NUM_CELLS:0]       chain_ready;
    aftm_pix_t                chain_data [NUM_CELLS:0];

    assign pix_in  = s_tdata;
    assign m_tdata = pix_out;

    // coefficient products and clamp test
    aftm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (pix_in),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // divider chain, one quotient bit per cell
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        aftm_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    // rounding and result register
    aftm_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[NUM_CELLS]),
        .in_ready  (chain_ready[NUM_CELLS]),
        .in_data   (chain_data[NUM_CELLS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (pix_out)
    );

    // checks
    `AFTM_CHECK(a_out_range, aclk, aresetn, m_tvalid, (pix_out[0] <= OUT_ONE) && (pix_out[1] <= OUT_ONE) && (pix_out[2] <= OUT_ONE), "result above 1.0")
    `AFTM_CHECK_NEXT(a_clamp_red, aclk, aresetn, chain_valid[NUM_CELLS] && chain_ready[NUM_CELLS] && chain_data[NUM_CELLS][0].clamp, m_tvalid && (pix_out[0] == OUT_ONE), "clamped red not 1.0")
    `AFTM_CHECK_NEXT(a_chain_hold, aclk, aresetn, chain_valid[0] && !chain_ready[0], chain_valid[0], "request lost in stalled chain")

endmodule

`default_nettype wire

FILE: tb/tb_aces_filmic_tone_map_unit.sv
// self-checking testbench for the aces filmic tone map unit, streaming in and out
// depends on aftm_pkg and aces_filmic_tone_map_unit; predicts in fixed point every pixel whose result is not typed in
`timescale 1ns / 100ps

module tb_aces_filmic_tone_map_unit;

    import aftm_pkg::*;

    localparam int N_DIR        = 14;
    localparam int HOLD_ITEMS   = 60;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 376;
    localparam int SETTLE       = 40;
    localparam int STALL_LIMIT  = 2000;

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    // one directed request, with its result typed in where it is obvious
    typedef struct {
        aftm_in_t  px;
        bit        typed;
        aftm_out_t want;
    } tone_case_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // red_in [23:0], green_in [47:24], blue_in [71:48]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // red_out [15:0], green_out [31:16], blue_out [47:32]

    aftm_out_t   mapped_due_q [$];
    tone_case_t  dir_cases [N_DIR];
    rx_mode_t    rx_mode;
    bit          hold_off_req;
    int          fail_count;
    int          quiet_cycles;

    aces_filmic_tone_map_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // curve coefficient in the input format, halves rounded up
    function automatic logic [63:0] coef_fx(input int unsigned hundredths);
        return ((64'(hundredths) << INPUT_FRAC_BITS) + 64'd50) / 64'd100;
    endfunction

    // y = x(2.51x + 0.03) / (x(2.43x + 0.59) + 0.14), clamped, as q1.15
    function automatic logic [OUT_W-1:0] aces_curve(input logic [IN_W-1:0] x);
        logic [63:0] xv, n, m, num, den, rem, q;
        xv  = 64'(x);
        n   = (coef_fx(251) * xv + (coef_fx(3) << INPUT_FRAC_BITS)) >> INPUT_FRAC_BITS;
        m   = (coef_fx(243) * xv + (coef_fx(59) << INPUT_FRAC_BITS)) >> INPUT_FRAC_BITS;
        num = xv * n;
        den = xv * m + (coef_fx(14) << INPUT_FRAC_BITS);
        if (num >= den)
            return OUT_ONE;
        // sixteen quotient bits by restoring division, then round half up
        rem = num;
        q   = '0;
        for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = q | 64'd1;
            end
        end
        q = (q + 64'd1) >> 1;
        if (q > 64'(OUT_ONE))
            q = 64'(OUT_ONE);
        return q[OUT_W-1:0];
    endfunction

    function automatic aftm_out_t map_pixel(input aftm_in_t px);
        aftm_out_t mapped;
        for (int ch = 0; ch < NUM_CH; ch++)
            mapped[ch] = aces_curve(px[ch]);
        return mapped;
    endfunction

    // radiance weighted towards the curve body and the knee near 7.24
    function automatic logic [IN_W-1:0] rand_radiance();
        logic [IN_W-1:0] v;
        case ($urandom_range(0, 9))
            0:          v = IN_W'($urandom);
            1:          v = IN_W'($urandom_range(0, 24'h00FFFF));
            2, 3, 4, 5: v = IN_W'($urandom_range(0, 24'h080000));
            6, 7:       v = IN_W'($urandom_range(24'h070000, 24'h078000));
            8:          v = IN_W'(1) << $urandom_range(0, IN_W - 1);
            default:    v = $urandom_range(0, 1) ? '1 : '0;
        endcase
        return v;
    endfunction

    function automatic aftm_in_t rand_pixel();
        aftm_in_t px;
        for (int ch = 0; ch < NUM_CH; ch++)
            px[ch] = rand_radiance();
        return px;
    endfunction

    // hold one request on s_ until it is taken, then log its result as due
    task automatic offer_pixel(input aftm_in_t px, input aftm_out_t want);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        mapped_due_q.push_back(want);
    endtask

    // sender gap, with junk on the data lines
    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 72'({$urandom, $urandom, $urandom});
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (mapped_due_q.size() != 0)
            @(posedge aclk);
    endtask

    // receiver: free running, random stalls or a fixed pattern, plus one long hold-off
    initial begin : receiver
        logic [15:0] rx_pattern;
        int          rx_phase;
        rx_pattern = 16'b1101_1010_0111_0110;
        rx_phase   = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        m_tready <= rx_pattern[rx_phase];
                        rx_phase = (rx_phase + 1) % 16;
                    end
                endcase
            end
        end
    end

    // compare each result with the oldest one due
    always @(posedge aclk) begin : result_check
        aftm_out_t want;
        aftm_out_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (mapped_due_q.size() == 0) begin
                $display("%0t: result %h with no request pending", $time, got);
                fail_count++;
            end else begin
                want = mapped_due_q.pop_front();
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    if (got[ch] !== want[ch]) begin
                        $display("%0t: channel %0d expected %0d got %0d",
                                 $time, ch, want[ch], got[ch]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        aftm_in_t px;
        int       sent;
        int       burst;
        bit       drained_mid;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        rx_mode      = RX_FREE;
        hold_off_req = 1'b0;
        fail_count   = 0;
        quiet_cycles = 0;

        // pixels written blue, green, red
        dir_cases = '{
            '{ {24'h000000, 24'h000000, 24'h000000}, 1'b1, {3{16'd0}} },
            '{ {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1, {3{OUT_ONE}} },
            '{ {24'h800000, 24'h100000, 24'h080000}, 1'b1, {3{OUT_ONE}} },
            '{ {24'h000000, 24'hFFFFFF, 24'h000000}, 1'b1, {16'd0, OUT_ONE, 16'd0} },
            '{ {24'h200000, 24'h400000, 24'h7FFFFF}, 1'b1, {3{OUT_ONE}} },
            '{ {24'h000003, 24'h000002, 24'h000001}, 1'b0, '0 },
            '{ {24'h004000, 24'h008000, 24'h010000}, 1'b0, '0 },
            '{ {24'h074000, 24'h073D70, 24'h073000}, 1'b0, '0 },
            '{ {24'h0F0F0F, 24'h555555, 24'hAAAAAA}, 1'b0, '0 },
            '{ {24'h00FFFF, 24'h001000, 24'h000100}, 1'b0, '0 },
            '{ {24'h050000, 24'h030000, 24'h020000}, 1'b0, '0 },
            '{ {24'h07FFFF, 24'h070000, 24'h060000}, 1'b0, '0 },
            '{ {24'h000FFF, 24'h0000FF, 24'h00001F}, 1'b0, '0 },
            '{ {24'h073D71, 24'h073D6F, 24'h0001C0}, 1'b0, '0 }
        };

        repeat (11)
            @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed requests back to back, then wait for every result
        foreach (dir_cases[i])
            offer_pixel(dir_cases[i].px,
                        dir_cases[i].typed ? dir_cases[i].want : map_pixel(dir_cases[i].px));
        drain_results();

        // long receiver hold-off while the sender keeps pushing, so the pipe backs up
        rx_mode      = RX_PATTERN;
        hold_off_req = 1'b1;
        repeat (HOLD_ITEMS) begin
            px = rand_pixel();
            offer_pixel(px, map_pixel(px));
        end

        // random bursts and gaps, receiver style changed per burst
        sent        = 0;
        drained_mid = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst   = $urandom_range(1, 24);
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            repeat (burst) begin
                px = rand_pixel();
                offer_pixel(px, map_pixel(px));
                sent++;
            end
            if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
                drain_results();
                drained_mid = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 20));
            end
        end

        drain_results();
        repeat (SETTLE)
            @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
